>>> hdl/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types, opcode codes and target encodings for the bytecode translator.
// ----------------------------------------------------------------------------
`default_nettype none

package bct_pkg;

  // source opcodes
  localparam logic [7:0] OP_MOV     = 8'h00;
  localparam logic [7:0] OP_ADD     = 8'h01;
  localparam logic [7:0] OP_FADD    = 8'h03;
  localparam logic [7:0] OP_FMUL    = 8'h04;
  localparam logic [7:0] OP_SEND    = 8'h20;
  localparam logic [7:0] OP_BARRIER = 8'h30;

  // target first dwords
  localparam logic [31:0] TGT_MOV     = 32'h5000_0001;
  localparam logic [31:0] TGT_ADD     = 32'h4000_0001;
  localparam logic [31:0] TGT_FMUL    = 32'h4600_0001;
  localparam logic [31:0] TGT_SEND    = 32'h4200_0000;
  localparam logic [31:0] TGT_BARRIER = 32'h7000_0000;

  localparam logic [9:0] BARRIER_CTRL = 10'h00F;

  // up to four source bytes of one instruction, or of several at packet end, byte 0 in the low lane
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
    logic            last;
  } group_t;

  typedef struct packed {
    logic [31:0] word0;
    logic [9:0]  word1;
    logic [9:0]  word2;
    logic [9:0]  word3;
    logic        was_unknown;
    logic [2:0]  used;
  } result_t;

  function automatic logic [2:0] op_length(input logic [7:0] op);
    logic [2:0] len;
    unique case (op)
      OP_MOV:                             len = 3'd3;
      OP_ADD, OP_FADD, OP_FMUL, OP_SEND:  len = 3'd4;
      OP_BARRIER:                         len = 3'd2;
      default:                            len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [9:0] reg_field(input logic [7:0] b);
    return {b[5:0], 4'b0000};
  endfunction

endpackage

`default_nettype wire

>>> hdl/bytecode_opcode_translator_unit.sv
// ----------------------------------------------------------------------------
// bytecode_opcode_translator_unit
// Translates a bytecode packet, one byte per request, into 62-bit target
// instructions, one result per decoded source instruction.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_*       in   tdata: byte_value; tlast: last_byte
//  m_*       out  tdata: word0..word3; tuser: was_unknown, run_last;
//                 tlast: packet_end
//
//  One byte accepted per cycle while s_tready is high; a completed group goes
//  to the group register, and its result then to the output register.
//  The packet's last byte may produce up to four results, sent one per cycle
//  by the group register unless the output stalls; it takes no new byte until
//  its final result moves. Output stalls back up through the output register
//  into the input side. rst clears the held-byte count, group and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bytecode_opcode_translator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [31:0] word0, [41:32] word1, [51:42] word2,
                                      // [61:52] word3, [63:62] zero
  output logic [1:0]       m_tuser,   // [0] was_unknown, [1] run_last
  output logic             m_tlast    // packet_end
);

  bct_pkg::group_t  cand;
  bct_pkg::group_t  grp;
  bct_pkg::result_t dec;
  logic             emit;
  logic             accept;
  logic             grp_valid;
  logic             out_load;
  logic             grp_final;

  bct_gather u_gather (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_value (s_tdata),
    .last_byte  (s_tlast),
    .grp        (cand),
    .emit       (emit)
  );

  bct_decode u_decode (
    .grp (grp),
    .res (dec)
  );

  assign out_load  = grp_valid && (!m_tvalid || m_tready);
  assign grp_final = (dec.used == grp.cnt);
  assign s_tready  = !grp_valid || (out_load && grp_final);
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
    end else if (accept && emit) begin
      grp_valid <= 1'b1;
    end else if (out_load && grp_final) begin
      grp_valid <= 1'b0;
    end
  end

  // consumed bytes shift out so the decoder always looks at lane 0
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      grp <= cand;
    end else if (out_load) begin
      grp.bytes <= grp.bytes >> {dec.used, 3'b000};
      grp.cnt   <= grp.cnt - dec.used;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, dec.word3, dec.word2, dec.word1, dec.word0};
      m_tuser <= {grp_final, dec.was_unknown};
      m_tlast <= grp_final && grp.last;
    end
  end

  a_grp_not_empty : assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> (grp.cnt != 3'd0 && grp.cnt <= 3'd4))
    else $error("group register holds no bytes");

  a_take_only_on_final : assert property (@(posedge clk) disable iff (rst)
    (accept && grp_valid) |-> (out_load && grp_final))
    else $error("byte taken while a group still has results pending");

  a_end_is_run_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser[1])
    else $error("packet end without run end");

  a_unknown_is_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0))
    else $error("no-op result carries data");

endmodule

`default_nettype wire

>>> hdl/bct_gather.sv
// ----------------------------------------------------------------------------
// bct_gather
// Holds bytes of an unfinished instruction and forms an instruction group
// once it is complete or the packet ends.
// ----------------------------------------------------------------------------
`default_nettype none

module bct_gather (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      byte_value,
  input  wire logic            last_byte,
  output bct_pkg::group_t      grp,
  output logic                 emit
);

  logic [7:0] held [3];
  logic [1:0] held_count;
  logic [2:0] n;
  logic [2:0] len;

  always_comb begin
    grp.bytes[0] = (held_count == 2'd0) ? byte_value : held[0];
    grp.bytes[1] = (held_count == 2'd1) ? byte_value :
                   (held_count > 2'd1)  ? held[1]    : 8'h00;
    grp.bytes[2] = (held_count == 2'd2) ? byte_value :
                   (held_count == 2'd3) ? held[2]    : 8'h00;
    grp.bytes[3] = (held_count == 2'd3) ? byte_value : 8'h00;
    n            = {1'b0, held_count} + 3'd1;
    len          = bct_pkg::op_length(grp.bytes[0]);
    grp.cnt      = n;
    grp.last     = last_byte;
    emit         = last_byte || (n >= len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (accept) begin
      held_count <= emit ? 2'd0 : n[1:0];
    end
  end

  // incomplete instruction: at most three bytes are ever held
  always_ff @(posedge clk) begin
    if (accept && !emit && held_count != 2'd3) begin
      held[held_count] <= byte_value;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bct_decode.sv
// ----------------------------------------------------------------------------
// bct_decode
// Decodes the instruction at the head of a group into one target word set.
// ----------------------------------------------------------------------------
`default_nettype none

module bct_decode (
  input  wire bct_pkg::group_t grp,
  output bct_pkg::result_t     res
);

  logic [7:0] op;
  logic [2:0] len;

  always_comb begin
    op  = grp.bytes[0];
    len = bct_pkg::op_length(op);
    res = '0;
    // unknown opcode, or too few bytes left: no-op that eats one byte
    if (len > grp.cnt || len == 3'd1) begin
      res.was_unknown = 1'b1;
      res.used        = 3'd1;
    end else begin
      res.used = len;
      unique case (op)
        bct_pkg::OP_MOV: begin
          res.word0 = bct_pkg::TGT_MOV;
          res.word1 = bct_pkg::reg_field(grp.bytes[1]);
          res.word2 = bct_pkg::reg_field(grp.bytes[2]);
        end
        bct_pkg::OP_ADD, bct_pkg::OP_FADD, bct_pkg::OP_FMUL: begin
          res.word0 = (op == bct_pkg::OP_FMUL) ? bct_pkg::TGT_FMUL : bct_pkg::TGT_ADD;
          res.word1 = bct_pkg::reg_field(grp.bytes[1]);
          res.word2 = bct_pkg::reg_field(grp.bytes[2]);
          res.word3 = bct_pkg::reg_field(grp.bytes[3]);
        end
        bct_pkg::OP_SEND: begin
          res.word0 = bct_pkg::TGT_SEND;
          res.word3 = {2'b00, grp.bytes[3]};
        end
        default: begin
          res.word0 = bct_pkg::TGT_BARRIER;
          res.word3 = bct_pkg::BARRIER_CTRL;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> dv/bytecode_opcode_translator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bytecode_opcode_translator_unit_tb
// Streams bytecode packets into the translator with random gaps and output
// stalls. Each accepted byte is decoded by a behavioral translator in the
// bench, and every target instruction that comes out is compared with the
// oldest one predicted.
// ----------------------------------------------------------------------------

module bytecode_opcode_translator_unit_tb;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES = 300;

  typedef struct packed {
    logic [31:0] word0;
    logic [9:0]  word1;
    logic [9:0]  word2;
    logic [9:0]  word3;
    logic        was_unknown;
    logic        run_last;
    logic        packet_end;
  } instr_t;

  typedef struct {
    logic [7:0]  value;
    logic        last;
    int unsigned gap;
    bit          drain;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  byte_req_t   byte_reqs[$];
  instr_t      pending_instrs[$];

  // translator state of the bench
  logic [7:0]  held [3];
  int unsigned held_n = 0;

  bit          req_taken = 1'b0;
  int unsigned gap_cnt = 0;
  int unsigned ready_left = 0;
  bit          ready_mode = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;

  bytecode_opcode_translator_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned instr_len(input logic [7:0] op);
    case (op)
      bct_pkg::OP_MOV:                                                   return 3;
      bct_pkg::OP_ADD, bct_pkg::OP_FADD, bct_pkg::OP_FMUL, bct_pkg::OP_SEND: return 4;
      bct_pkg::OP_BARRIER:                                               return 2;
      default:                                                           return 1;
    endcase
  endfunction

  // w[7:0] is the opcode byte; returns the number of bytes consumed
  function automatic int unsigned decode_instr(input logic [31:0] w, input int unsigned avail,
                                               output instr_t r);
    int unsigned len;
    len = instr_len(w[7:0]);
    r = '0;
    if (len > avail || len == 1) begin
      r.was_unknown = 1'b1;
      return 1;
    end
    case (w[7:0])
      bct_pkg::OP_MOV: begin
        r.word0 = bct_pkg::TGT_MOV;
        r.word1 = {w[13:8], 4'b0000};
        r.word2 = {w[21:16], 4'b0000};
      end
      bct_pkg::OP_ADD, bct_pkg::OP_FADD, bct_pkg::OP_FMUL: begin
        r.word0 = (w[7:0] == bct_pkg::OP_FMUL) ? bct_pkg::TGT_FMUL : bct_pkg::TGT_ADD;
        r.word1 = {w[13:8], 4'b0000};
        r.word2 = {w[21:16], 4'b0000};
        r.word3 = {w[29:24], 4'b0000};
      end
      bct_pkg::OP_SEND: begin
        r.word0 = bct_pkg::TGT_SEND;
        r.word3 = {2'b00, w[31:24]};
      end
      default: begin
        r.word0 = bct_pkg::TGT_BARRIER;
        r.word3 = bct_pkg::BARRIER_CTRL;
      end
    endcase
    return len;
  endfunction

  task automatic translate_byte(input logic [7:0] b, input logic last);
    logic [31:0] win;
    int unsigned n;
    int unsigned pos;
    instr_t r;
    win = '0;
    for (int i = 0; i < held_n; i++) win[i*8 +: 8] = held[i];
    win[held_n*8 +: 8] = b;
    n = held_n + 1;
    if (!last) begin
      if (n >= instr_len(win[7:0])) begin
        void'(decode_instr(win, n, r));
        r.run_last = 1'b1;
        pending_instrs.push_back(r);
        held_n = 0;
      end else begin
        for (int i = 0; i < n; i++) held[i] = win[i*8 +: 8];
        held_n = n;
      end
    end else begin
      // packet end: reparse everything held, truncated opcodes become no-ops
      pos = 0;
      while (pos < n) begin
        pos += decode_instr(win >> (pos * 8), n - pos, r);
        if (pos >= n) begin
          r.run_last = 1'b1;
          r.packet_end = 1'b1;
        end
        pending_instrs.push_back(r);
      end
      held_n = 0;
    end
  endtask

  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_op(input int unsigned idx);
    case (idx)
      0:       return bct_pkg::OP_MOV;
      1:       return bct_pkg::OP_ADD;
      2:       return bct_pkg::OP_FADD;
      3:       return bct_pkg::OP_FMUL;
      4:       return bct_pkg::OP_SEND;
      default: return bct_pkg::OP_BARRIER;
    endcase
  endfunction

  function automatic void queue_byte(input logic [7:0] value, input logic last,
                                     input int unsigned gap, input bit drain);
    byte_req_t req;
    req.value = value;
    req.last  = last;
    req.gap   = gap;
    req.drain = drain;
    byte_reqs.push_back(req);
  endfunction

  // request driver
  byte_req_t cur_req;
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || req_taken)) begin
      req_taken = 1'b0;
      if (byte_reqs.size() == 0 || gap_cnt < byte_reqs[0].gap ||
          (byte_reqs[0].drain && pending_instrs.size() != 0)) begin
        if (byte_reqs.size() != 0) gap_cnt++;
        s_tvalid <= 1'b0;
      end else begin
        cur_req = byte_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= cur_req.value;
        s_tlast  <= cur_req.last;
        gap_cnt = 0;
      end
    end
  end

  // output backpressure: free stretches, short stalls, a few long ones
  int unsigned ready_pick;
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 40) begin
        ready_mode = 1'b1;
        ready_left = $urandom_range(1, 40);
      end else if (ready_pick < 92) begin
        ready_mode = 1'b0;
        ready_left = $urandom_range(1, 3);
      end else begin
        ready_mode = 1'b0;
        ready_left = $urandom_range(10, 30);
      end
    end
    ready_left--;
    m_tready <= ready_mode;
  end

  // monitor and checker
  instr_t got;
  instr_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        translate_byte(s_tdata, s_tlast);
        req_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got.word0       = m_tdata[31:0];
        got.word1       = m_tdata[41:32];
        got.word2       = m_tdata[51:42];
        got.word3       = m_tdata[61:52];
        got.was_unknown = m_tuser[0];
        got.run_last    = m_tuser[1];
        got.packet_end  = m_tlast;
        if (pending_instrs.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result w0=%h w1=%h w2=%h w3=%h unk=%b rl=%b end=%b",
                     got.word0, got.word1, got.word2, got.word3,
                     got.was_unknown, got.run_last, got.packet_end);
          mismatches++;
        end else begin
          want = pending_instrs.pop_front();
          if (got.word0 !== want.word0 || got.word1 !== want.word1 ||
              got.word2 !== want.word2 || got.word3 !== want.word3 ||
              got.was_unknown !== want.was_unknown || got.run_last !== want.run_last ||
              got.packet_end !== want.packet_end || m_tdata[63:62] !== 2'b00) begin
            if (mismatches < 10) begin
              $display("mismatch expected w0=%h w1=%h w2=%h w3=%h unk=%b rl=%b end=%b",
                       want.word0, want.word1, want.word2, want.word3,
                       want.was_unknown, want.run_last, want.packet_end);
              $display("         actual   w0=%h w1=%h w2=%h w3=%h unk=%b rl=%b end=%b",
                       got.word0, got.word1, got.word2, got.word3,
                       got.was_unknown, got.run_last, got.packet_end);
            end
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  logic [7:0]  pkt[$];
  logic [7:0]  op;
  int unsigned n_random;
  int unsigned pkt_cnt;
  int unsigned n_ins;
  int unsigned cut;
  bit          quiet;
  initial begin
    // directed: each opcode, register masking, unmasked binding index, unknowns
    queue_byte(bct_pkg::OP_MOV, 1'b0, 0, 1'b0);
    queue_byte(8'h3F, 1'b0, 0, 1'b0);
    queue_byte(8'hC0, 1'b0, 0, 1'b0);
    queue_byte(bct_pkg::OP_ADD, 1'b0, 0, 1'b0);
    queue_byte(8'hFF, 1'b0, 0, 1'b0);
    queue_byte(8'h00, 1'b0, 0, 1'b0);
    queue_byte(8'h2A, 1'b0, 0, 1'b0);
    queue_byte(bct_pkg::OP_FADD, 1'b0, 0, 1'b0);
    queue_byte(8'h15, 1'b0, 0, 1'b0);
    queue_byte(8'h2A, 1'b0, 0, 1'b0);
    queue_byte(8'h3F, 1'b0, 0, 1'b0);
    queue_byte(bct_pkg::OP_FMUL, 1'b0, 0, 1'b0);
    queue_byte(8'h80, 1'b0, 0, 1'b0);
    queue_byte(8'h7F, 1'b0, 0, 1'b0);
    queue_byte(8'h01, 1'b0, 0, 1'b0);
    queue_byte(bct_pkg::OP_SEND, 1'b0, 0, 1'b0);
    queue_byte(8'h11, 1'b0, 0, 1'b0);
    queue_byte(8'h22, 1'b0, 0, 1'b0);
    queue_byte(8'hFF, 1'b0, 0, 1'b0);
    queue_byte(bct_pkg::OP_BARRIER, 1'b0, 0, 1'b0);
    queue_byte(8'hAA, 1'b0, 0, 1'b0);
    queue_byte(8'hFF, 1'b0, 0, 1'b0);
    // truncated add at packet end: three no-ops
    queue_byte(bct_pkg::OP_ADD, 1'b0, 0, 1'b0);
    queue_byte(bct_pkg::OP_MOV, 1'b0, 0, 1'b0);
    queue_byte(bct_pkg::OP_BARRIER, 1'b1, 0, 1'b0);
    // lone mov opcode as the last byte
    queue_byte(bct_pkg::OP_MOV, 1'b1, 0, 1'b0);

    // random packets: mostly well-formed instructions, some noise, optional cut tail
    n_random = 0;
    pkt_cnt = 0;
    while (n_random < RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 9) < 3);
      n_ins = $urandom_range(1, 8);
      pkt.delete();
      for (int j = 0; j < n_ins; j++) begin
        if ($urandom_range(0, 9) < 8) begin
          op = pick_op($urandom_range(0, 5));
          pkt.push_back(op);
          for (int k = 1; k < instr_len(op); k++) pkt.push_back($urandom_range(0, 255));
        end else begin
          pkt.push_back($urandom_range(0, 255));
        end
      end
      if ($urandom_range(0, 1)) begin
        op = pick_op($urandom_range(0, 5));
        cut = $urandom_range(1, instr_len(op) - 1);
        pkt.push_back(op);
        for (int k = 1; k < cut; k++) pkt.push_back($urandom_range(0, 255));
      end
      for (int j = 0; j < pkt.size(); j++)
        queue_byte(pkt[j], j == pkt.size() - 1, quiet ? 0 : next_gap(),
                   j == 0 && pkt_cnt % 6 == 0);
      n_random += pkt.size();
      pkt_cnt++;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_reqs.size() != 0 || s_tvalid) @(posedge clk);
    while (pending_instrs.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (mismatches == 0 && pending_instrs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
